// File: rtl/bfrv_pkg.sv
`default_nettype none

package bfrv_pkg;

    // Widths fixed by the item formats.
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int LEN_W   = 9;
    localparam int STAT_W  = 3;
    localparam int CNT_W   = 16;
    localparam int CRC_W   = 16;
    localparam int HDR_N   = 5;
    localparam int PLEN_W  = 16;
    localparam int OUT_W   = STAT_W + BYTE_W + LEN_W + 3 * CNT_W;
    localparam int OUT_PAD = ((OUT_W + 7) / 8) * 8 - OUT_W;

    localparam int MAX_CAPTURE_DEF = 280;

    // Event kinds on the input channel.
    localparam logic [KIND_W-1:0] KIND_ADDR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP = 2'd2;

    // Frame status codes.
    localparam logic [STAT_W-1:0] ST_MALFORMED = 3'd0;
    localparam logic [STAT_W-1:0] ST_CRC_ERR   = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_ADDR  = 3'd2;
    localparam logic [STAT_W-1:0] ST_MSG       = 3'd3;
    localparam logic [STAT_W-1:0] ST_CTRL      = 3'd4;
    localparam logic [STAT_W-1:0] ST_UNREG     = 3'd5;

    // Frame format constants.
    localparam logic [CRC_W-1:0]  CRC_INIT     = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY     = 16'h1021;
    localparam logic [BYTE_W-1:0] TYPE_SHORT   = 8'h01;
    localparam logic [BYTE_W-1:0] TYPE_CTRL    = 8'h12;
    localparam logic [BYTE_W-1:0] TYPE_LONG_LO = 8'h10;
    localparam logic [BYTE_W-1:0] VER_MASK     = 8'hE0;
    localparam logic [BYTE_W-1:0] VER_VALUE    = 8'h20;
    localparam logic [BYTE_W-1:0] DEST_BCAST   = 8'h00;
    localparam logic [BYTE_W-1:0] NODE_ADDR_RST = 8'hFF;
    localparam int                PLEN_MAX     = 256;
    localparam int                SHORT_OVH    = 4;
    localparam int                LONG_OVH     = 9;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              inc_accept;
        logic              inc_crc_err;
        logic              inc_drop;
    } check_res_t;

    // One byte of CRC16-CCITT, MSB first.
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[CRC_W-1])
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/bus_frame_receive_validator.sv
`default_nettype none

// Channel   Handshake                     Payload
// s_axis    s_axis_tvalid/s_axis_tready   tdata: data_byte; tuser: kind
// m_axis    m_axis_tvalid/m_axis_tready   tdata: status, frame_type, frame_length, counters
// cfg       cfg_wr_en                     cfg_wr_data: node_address
//
// An accepted item sits in the input register until it is processed, so one item per
// cycle while no stop waits for a full result register. A stop's result is loaded into
// the result register at the edge at which the stop is processed, and leaves from there.
// An item is held in the input register only while a stop waits for a full result
// register. Reset clears the transaction state, the counters and both valid flags,
// and sets node_address to 255.

module bus_frame_receive_validator
    import bfrv_pkg::*;
#(
    parameter int MAX_CAPTURE = MAX_CAPTURE_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              cfg_wr_en,
    input  wire logic [BYTE_W-1:0] cfg_wr_data,

    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic [KIND_W-1:0] s_axis_tuser,   // [1:0] kind

    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // [2:0] status, [10:3] frame_type, [19:11] frame_length, [35:20] accepted_count,
    // [51:36] crc_error_count, [67:52] drop_count, [71:68] zero
    output logic [OUT_W+OUT_PAD-1:0] m_axis_tdata
);

    logic [BYTE_W-1:0] node_address_reg;

    // Input register.
    logic              in_valid_reg;
    logic [KIND_W-1:0] in_kind_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // Capture state.
    logic              in_trans_reg,  in_trans_next;
    logic [LEN_W-1:0]  count_reg,     count_next;
    logic [CRC_W-1:0]  crc_reg,       crc_next;
    logic [BYTE_W-1:0] tail_reg [2];
    logic [BYTE_W-1:0] tail_next [2];
    logic [BYTE_W-1:0] hdr_reg [HDR_N];
    logic [BYTE_W-1:0] hdr_next [HDR_N];
    logic [CNT_W-1:0]  acc_reg,  acc_next;
    logic [CNT_W-1:0]  crce_reg, crce_next;
    logic [CNT_W-1:0]  drop_reg, drop_next;

    // Result register.
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_data_reg;

    logic       advance;
    logic       emit;
    check_res_t chk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_address_reg <= NODE_ADDR_RST;
        else if (cfg_wr_en)
            node_address_reg <= cfg_wr_data;
    end

    // A stop may need the result register; anything else always moves on.
    assign advance = in_valid_reg
                     && (in_kind_reg != KIND_STOP || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_kind_reg <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
    end

    bfrv_frame_check u_check (
        .byte_count   (count_reg),
        .hdr_type     (hdr_reg[0]),
        .hdr_ver      (hdr_reg[1]),
        .hdr_dest     (hdr_reg[2]),
        .hdr_plen_lo  (hdr_reg[3]),
        .hdr_plen_hi  (hdr_reg[4]),
        .tail_old     (tail_reg[0]),
        .tail_new     (tail_reg[1]),
        .running_crc  (crc_reg),
        .node_address (node_address_reg),
        .res          (chk)
    );

    always_comb
    begin
        in_trans_next = in_trans_reg;
        count_next    = count_reg;
        crc_next      = crc_reg;
        tail_next     = tail_reg;
        hdr_next      = hdr_reg;
        acc_next      = acc_reg;
        crce_next     = crce_reg;
        drop_next     = drop_reg;
        emit          = 1'b0;
        if (advance)
        begin
            unique case (in_kind_reg)
                KIND_ADDR:
                begin
                    in_trans_next = 1'b1;
                    count_next    = '0;
                    crc_next      = CRC_INIT;
                    tail_next[0]  = '0;
                    tail_next[1]  = '0;
                    for (int i = 0; i < HDR_N; i++)
                        hdr_next[i] = '0;
                end
                KIND_DATA:
                begin
                    if (in_trans_reg && count_reg < LEN_W'(MAX_CAPTURE))
                    begin
                        case (count_reg)
                            LEN_W'(0): hdr_next[0] = in_byte_reg;
                            LEN_W'(1): hdr_next[1] = in_byte_reg;
                            LEN_W'(2): hdr_next[2] = in_byte_reg;
                            LEN_W'(5): hdr_next[3] = in_byte_reg;
                            LEN_W'(6): hdr_next[4] = in_byte_reg;
                            default:   ;
                        endcase
                        // The last two bytes are the CRC itself and stay out of it.
                        if (count_reg >= LEN_W'(2))
                            crc_next = crc_feed(crc_reg, tail_reg[0]);
                        tail_next[0] = tail_reg[1];
                        tail_next[1] = in_byte_reg;
                        count_next   = count_reg + LEN_W'(1);
                    end
                end
                KIND_STOP:
                begin
                    if (in_trans_reg)
                    begin
                        in_trans_next = 1'b0;
                        if (count_reg != '0)
                        begin
                            emit       = 1'b1;
                            count_next = '0;
                            acc_next   = acc_reg  + CNT_W'(chk.inc_accept);
                            crce_next  = crce_reg + CNT_W'(chk.inc_crc_err);
                            drop_next  = drop_reg + CNT_W'(chk.inc_drop);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_trans_reg <= 1'b0;
            count_reg    <= '0;
            crc_reg      <= CRC_INIT;
            tail_reg[0]  <= '0;
            tail_reg[1]  <= '0;
            for (int i = 0; i < HDR_N; i++)
                hdr_reg[i] <= '0;
            acc_reg      <= '0;
            crce_reg     <= '0;
            drop_reg     <= '0;
        end
        else
        begin
            in_trans_reg <= in_trans_next;
            count_reg    <= count_next;
            crc_reg      <= crc_next;
            tail_reg     <= tail_next;
            hdr_reg      <= hdr_next;
            acc_reg      <= acc_next;
            crce_reg     <= crce_next;
            drop_reg     <= drop_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_data_reg <= {drop_next, crce_next, acc_next, count_reg, hdr_reg[0], chk.status};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_data_reg};

endmodule

`default_nettype wire

// File: rtl/bfrv_frame_check.sv
`default_nettype none

module bfrv_frame_check
    import bfrv_pkg::*;
(
    input  wire logic [LEN_W-1:0]  byte_count,
    input  wire logic [BYTE_W-1:0] hdr_type,
    input  wire logic [BYTE_W-1:0] hdr_ver,
    input  wire logic [BYTE_W-1:0] hdr_dest,
    input  wire logic [BYTE_W-1:0] hdr_plen_lo,
    input  wire logic [BYTE_W-1:0] hdr_plen_hi,
    input  wire logic [BYTE_W-1:0] tail_old,
    input  wire logic [BYTE_W-1:0] tail_new,
    input  wire logic [CRC_W-1:0]  running_crc,
    input  wire logic [BYTE_W-1:0] node_address,
    output check_res_t             res
);

    logic [CRC_W-1:0]  rx_crc;
    logic [PLEN_W-1:0] plen;
    logic [PLEN_W:0]   long_len;
    logic [LEN_W:0]    short_len;
    logic              is_short;
    logic              is_long;
    logic              crc_ok;
    logic              valid_ok;

    assign rx_crc    = {tail_new, tail_old};
    assign plen      = {hdr_plen_hi, hdr_plen_lo};
    assign long_len  = {1'b0, plen} + (PLEN_W+1)'(LONG_OVH);
    assign short_len = (LEN_W+1)'(hdr_ver) + (LEN_W+1)'(SHORT_OVH);
    assign is_short  = (byte_count >= LEN_W'(SHORT_OVH)) && (hdr_type == TYPE_SHORT);
    assign is_long   = (byte_count >= LEN_W'(LONG_OVH)) && (hdr_type >= TYPE_LONG_LO);
    assign crc_ok    = (running_crc == rx_crc);

    always_comb
    begin
        res      = '0;
        valid_ok = 1'b0;
        if (is_short)
        begin
            if (hdr_ver == '0 || short_len != {1'b0, byte_count})
            begin
                res.status   = ST_MALFORMED;
                res.inc_drop = 1'b1;
            end
            else if (!crc_ok)
            begin
                res.status      = ST_CRC_ERR;
                res.inc_crc_err = 1'b1;
            end
            else
            begin
                valid_ok = 1'b1;
            end
        end
        else if (is_long)
        begin
            if ((hdr_ver & VER_MASK) != VER_VALUE
                || long_len != (PLEN_W+1)'(byte_count)
                || plen > PLEN_W'(PLEN_MAX))
            begin
                res.status   = ST_MALFORMED;
                res.inc_drop = 1'b1;
            end
            else if (!crc_ok)
            begin
                res.status      = ST_CRC_ERR;
                res.inc_crc_err = 1'b1;
            end
            else if (hdr_dest != DEST_BCAST && hdr_dest != node_address)
            begin
                res.status = ST_NOT_ADDR;
            end
            else
            begin
                valid_ok = 1'b1;
            end
        end
        else
        begin
            res.status   = ST_MALFORMED;
            res.inc_drop = 1'b1;
        end

        // A valid frame of a type nobody handles is both accepted and dropped.
        if (valid_ok)
        begin
            res.inc_accept = 1'b1;
            if (hdr_type == TYPE_SHORT)
                res.status = ST_MSG;
            else if (hdr_type == TYPE_CTRL)
                res.status = ST_CTRL;
            else
            begin
                res.status   = ST_UNREG;
                res.inc_drop = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: tb/bus_frame_receive_validator_test.sv
`timescale 1ns / 100ps

module bus_frame_receive_validator_test;
    import bfrv_pkg::*;

    // The block ignores the fourth kind code; the package has no name for it.
    localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [OUT_PAD-1:0] pad;
        logic [CNT_W-1:0]   drops;
        logic [CNT_W-1:0]   crc_errors;
        logic [CNT_W-1:0]   accepted;
        logic [LEN_W-1:0]   length;
        logic [BYTE_W-1:0]  ftype;
        logic [STAT_W-1:0]  status;
    } verdict_t;

    class frame_verdict_board;
        logic [BYTE_W-1:0] node_addr;
        bit                open_txn;
        int                captured;
        logic [CRC_W-1:0]  crc;
        logic [BYTE_W-1:0] tail [2];
        logic [BYTE_W-1:0] hdr [HDR_N];
        logic [CNT_W-1:0]  accepted;
        logic [CNT_W-1:0]  crc_errors;
        logic [CNT_W-1:0]  drops;
        verdict_t          pending_verdicts [$];
        int                errors;

        function new();
            node_addr  = NODE_ADDR_RST;
            open_txn   = 1'b0;
            accepted   = '0;
            crc_errors = '0;
            drops      = '0;
            errors     = 0;
            clear_capture();
        endfunction

        // Bitwise form of the CCITT polynomial, most significant bit first.
        static function logic [CRC_W-1:0] crc_byte(logic [CRC_W-1:0] c, logic [BYTE_W-1:0] b);
            logic fb;
            for (int i = BYTE_W - 1; i >= 0; i--)
            begin
                fb = c[CRC_W-1] ^ b[i];
                c  = {c[CRC_W-2:0], 1'b0};
                if (fb)
                    c = c ^ CRC_POLY;
            end
            return c;
        endfunction

        function void clear_capture();
            captured = 0;
            crc      = CRC_INIT;
            tail[0]  = '0;
            tail[1]  = '0;
            foreach (hdr[i])
                hdr[i] = '0;
        endfunction

        function verdict_t judge();
            verdict_t         v;
            int               plen;
            logic [CRC_W-1:0] rx;
            bit               ok;
            v        = '0;
            v.ftype  = hdr[0];
            v.length = LEN_W'(captured);
            v.status = ST_MALFORMED;
            rx       = {tail[1], tail[0]};
            plen     = {hdr[4], hdr[3]};
            ok       = 1'b0;
            if (captured >= SHORT_OVH && hdr[0] == TYPE_SHORT)
            begin
                if (hdr[1] == 0 || captured != SHORT_OVH + hdr[1])
                    drops++;
                else if (crc != rx)
                begin
                    v.status = ST_CRC_ERR;
                    crc_errors++;
                end
                else
                    ok = 1'b1;
            end
            else if (captured >= LONG_OVH && hdr[0] >= TYPE_LONG_LO)
            begin
                if ((hdr[1] & VER_MASK) != VER_VALUE || captured != LONG_OVH + plen
                    || plen > PLEN_MAX)
                    drops++;
                else if (crc != rx)
                begin
                    v.status = ST_CRC_ERR;
                    crc_errors++;
                end
                else if (hdr[2] != DEST_BCAST && hdr[2] != node_addr)
                    v.status = ST_NOT_ADDR;
                else
                    ok = 1'b1;
            end
            else
                drops++;
            if (ok)
            begin
                accepted++;
                if (hdr[0] == TYPE_SHORT)
                    v.status = ST_MSG;
                else if (hdr[0] == TYPE_CTRL)
                    v.status = ST_CTRL;
                else
                begin
                    // A frame of an unknown type is both accepted and dropped.
                    v.status = ST_UNREG;
                    drops++;
                end
            end
            v.accepted   = accepted;
            v.crc_errors = crc_errors;
            v.drops      = drops;
            return v;
        endfunction

        function void take_event(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] b);
            case (kind)
                KIND_ADDR:
                begin
                    open_txn = 1'b1;
                    clear_capture();
                end
                KIND_DATA:
                begin
                    if (open_txn && captured < MAX_CAPTURE_DEF)
                    begin
                        case (captured)
                            0: hdr[0] = b;
                            1: hdr[1] = b;
                            2: hdr[2] = b;
                            5: hdr[3] = b;
                            6: hdr[4] = b;
                            default: ;
                        endcase
                        // The last two bytes are the CRC itself, so the sum lags by two.
                        if (captured >= 2)
                            crc = crc_byte(crc, tail[0]);
                        tail[0] = tail[1];
                        tail[1] = b;
                        captured++;
                    end
                end
                KIND_STOP:
                begin
                    if (open_txn)
                    begin
                        open_txn = 1'b0;
                        if (captured != 0)
                            pending_verdicts.push_back(judge());
                        captured = 0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(verdict_t got);
            verdict_t want;
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual status %0d type %0d length %0d",
                         $time, got.status, got.ftype, got.length);
                errors++;
                return;
            end
            want = pending_verdicts.pop_front();
            compare("status", want.status, got.status);
            compare("frame_type", want.ftype, got.ftype);
            compare("frame_length", want.length, got.length);
            compare("accepted_count", want.accepted, got.accepted);
            compare("crc_error_count", want.crc_errors, got.crc_errors);
            compare("drop_count", want.drops, got.drops);
            compare("tdata padding", want.pad, got.pad);
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [BYTE_W-1:0]       cfg_wr_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [BYTE_W-1:0]       s_axis_tdata;   // [7:0] data_byte
    logic [KIND_W-1:0]       s_axis_tuser;   // [1:0] kind
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    // [2:0] status, [10:3] frame_type, [19:11] frame_length, [35:20] accepted_count,
    // [51:36] crc_error_count, [67:52] drop_count, [71:68] zero
    logic [OUT_W+OUT_PAD-1:0] m_axis_tdata;

    frame_verdict_board sb = new();
    bit                 src_steady  = 1'b0;
    bit                 sink_steady = 1'b0;
    bit                 hold_sink   = 1'b0;
    int                 items_sent  = 0;
    logic [BYTE_W-1:0]  frame_bytes [$];

    bus_frame_receive_validator uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Called at a falling edge; returns at the falling edge after the item was taken,
    // with tvalid still high so that a back-to-back item keeps it up.
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] b);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.take_event(kind, b);
        if (kind != KIND_IGNORED)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input bit decorate);
        if (decorate && $urandom_range(0, 19) == 0)
            send_item(KIND_DATA, 8'($urandom));
        if (decorate && $urandom_range(0, 14) == 0)
        begin
            // A second address in the middle of a transaction restarts the capture.
            send_item(KIND_ADDR, 8'($urandom));
            repeat ($urandom_range(0, 5))
                send_item(KIND_DATA, 8'($urandom));
        end
        send_item(KIND_ADDR, 8'($urandom));
        foreach (frame_bytes[i])
        begin
            if (decorate && $urandom_range(0, 39) == 0)
                send_item(KIND_IGNORED, 8'($urandom));
            send_item(KIND_DATA, frame_bytes[i]);
        end
        if (!decorate || $urandom_range(0, 24) != 0)
            send_item(KIND_STOP, 8'($urandom));
        if (decorate && $urandom_range(0, 14) == 0)
            send_item(KIND_STOP, 8'($urandom));
    endtask

    function automatic void seal_crc();
        logic [CRC_W-1:0] c;
        c = CRC_INIT;
        foreach (frame_bytes[i])
            c = frame_verdict_board::crc_byte(c, frame_bytes[i]);
        frame_bytes.push_back(c[7:0]);
        frame_bytes.push_back(c[15:8]);
    endfunction

    function automatic void build_short(input int len);
        frame_bytes.delete();
        frame_bytes.push_back(TYPE_SHORT);
        frame_bytes.push_back(8'(len));
        repeat (len)
            frame_bytes.push_back(8'($urandom));
        seal_crc();
    endfunction

    function automatic void build_long(input logic [BYTE_W-1:0] ftype,
                                       input logic [BYTE_W-1:0] dest, input int plen);
        frame_bytes.delete();
        frame_bytes.push_back(ftype);
        frame_bytes.push_back(VER_VALUE | 8'($urandom_range(0, 31)));
        frame_bytes.push_back(dest);
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(plen[7:0]);
        frame_bytes.push_back(plen[15:8]);
        repeat (plen)
            frame_bytes.push_back(8'($urandom));
        seal_crc();
    endfunction

    function automatic void build_noise(input int len);
        frame_bytes.delete();
        repeat (len)
            frame_bytes.push_back(8'($urandom));
        if (len != 0)
        begin
            case ($urandom_range(0, 2))
                0: frame_bytes[0] = TYPE_SHORT;
                1: frame_bytes[0] = TYPE_CTRL;
                default: ;
            endcase
        end
    endfunction

    task automatic random_frame();
        int                pick;
        int                len;
        int                idx;
        logic [BYTE_W-1:0] ftype;
        logic [BYTE_W-1:0] dest;
        if ($urandom_range(0, 9) == 0)
        begin
            src_steady  = ($urandom_range(0, 2) == 0);
            sink_steady = ($urandom_range(0, 2) == 0);
        end
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            len = ($urandom_range(0, 24) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 10);
            build_short(len);
        end
        else if (pick < 75)
        begin
            ftype = ($urandom_range(0, 3) != 0) ? TYPE_CTRL
                                               : 8'($urandom_range(TYPE_LONG_LO, 255));
            case ($urandom_range(0, 2))
                0: dest = DEST_BCAST;
                1: dest = sb.node_addr;
                default: dest = 8'($urandom);
            endcase
            case ($urandom_range(0, 39))
                0: len = PLEN_MAX;
                1: len = $urandom_range(PLEN_MAX + 1, MAX_CAPTURE_DEF - LONG_OVH);
                2: len = $urandom_range(100, PLEN_MAX);
                default: len = $urandom_range(0, 10);
            endcase
            build_long(ftype, dest, len);
        end
        else if (pick < 98)
            build_noise($urandom_range(0, 12));
        else
            build_noise($urandom_range(MAX_CAPTURE_DEF - 2, MAX_CAPTURE_DEF + 12));
        if (pick < 75)
        begin
            idx = $urandom_range(0, frame_bytes.size() - 1);
            case ($urandom_range(0, 11))
                0: frame_bytes[idx] = frame_bytes[idx] ^ 8'(1 << $urandom_range(0, 7));
                1:
                begin
                    idx = frame_bytes.size() - 1 - $urandom_range(0, 1);
                    frame_bytes[idx] = frame_bytes[idx] ^ 8'(1 << $urandom_range(0, 7));
                end
                2: void'(frame_bytes.pop_back());
                3: frame_bytes.push_back(8'($urandom));
                4: frame_bytes[1] = frame_bytes[1] ^ 8'h40;
                default: ;
            endcase
        end
        send_frame(1'b1);
    endtask

    task automatic drain(input int slack);
        s_axis_tvalid = 1'b0;
        while (sb.pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (slack) @(negedge clk);
    endtask

    task automatic write_node(input logic [BYTE_W-1:0] addr);
        drain(SETTLE_CYCLES);
        cfg_wr_data = addr;
        cfg_wr_en   = 1'b1;
        @(negedge clk);
        cfg_wr_en    = 1'b0;
        sb.node_addr = addr;
    endtask

    task automatic run_phase(input int span);
        int stop_at;
        stop_at = items_sent + span;
        while (items_sent < stop_at)
            random_frame();
    endtask

    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_sink = 1'b0;
            end
            stall = sink_steady ? 0 : $urandom_range(0, 15);
            if (stall != 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            sb.check_result(verdict_t'(m_axis_tdata));
        end
    end

    initial
    begin
        #2_000_000;
        $display("bus_frame_receive_validator: mismatch");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_ADDR;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Events that must leave no trace, then the smallest frames.
        send_item(KIND_IGNORED, 8'hFF);
        send_item(KIND_DATA, 8'hA5);
        send_item(KIND_STOP, 8'h00);
        send_item(KIND_ADDR, 8'h00);
        send_item(KIND_STOP, 8'hFF);
        frame_bytes = {8'h00};
        send_frame(1'b0);
        build_short(1);
        send_frame(1'b0);
        build_long(TYPE_CTRL, NODE_ADDR_RST, 0);
        send_frame(1'b0);

        write_node(8'h00);
        build_long(TYPE_CTRL, DEST_BCAST, PLEN_MAX);
        send_frame(1'b0);
        build_noise(MAX_CAPTURE_DEF + 5);
        send_frame(1'b0);
        run_phase(150);

        write_node(8'hFF);
        // Hold the result side off while frames keep coming, so the input backs up.
        hold_sink  = 1'b1;
        src_steady = 1'b1;
        repeat (8)
        begin
            build_short($urandom_range(1, 4));
            send_frame(1'b0);
        end
        src_steady = 1'b0;
        run_phase(150);

        write_node(8'($urandom_range(1, 254)));
        run_phase(150);
        write_node(8'($urandom_range(1, 254)));
        run_phase(150);

        drain(10);
        if (sb.errors == 0)
            $display("bus_frame_receive_validator: match");
        else
            $display("bus_frame_receive_validator: mismatch");
        $finish;
    end

endmodule

// File: bus_frame_receive_validator.f
rtl/bfrv_pkg.sv
rtl/bfrv_frame_check.sv
rtl/bus_frame_receive_validator.sv
tb/bus_frame_receive_validator_test.sv
